@@ hw/rtl/rbud_pkg.sv @@
// Shared types and constants for the RAW unpack / downscale block.
package rbud_pkg;

	localparam int QW = 14;	// dimension and quotient width
	localparam int NW = 28;	// divider numerator width
	localparam int DW = 15;	// divider denominator width
	localparam int PW = 30;	// packed byte offset width

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	localparam logic [1:0] FMT_RAW16 = 2'd0;
	localparam logic [1:0] FMT_RAW10 = 2'd1;
	localparam logic [1:0] FMT_RAW12 = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_CFG = 2'd1;
	localparam logic [1:0] ST_OFFSET  = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;

	localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd0;
	localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd1;
	localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd2;
	localparam logic [2:0] REG_ROW_STRIDE    = 3'd3;
	localparam logic [2:0] REG_PIXEL_STRIDE  = 3'd4;
	localparam logic [2:0] REG_OUTPUT_WIDTH  = 3'd5;
	localparam logic [2:0] REG_OUTPUT_HEIGHT = 3'd6;
	localparam logic [2:0] REG_BUF_USED      = 3'd7;

	typedef struct packed {
		logic [1:0]  pixel_format;
		logic [13:0] source_width;
		logic [13:0] source_height;
		logic [15:0] row_stride;
		logic [3:0]  pixel_stride;
		logic [13:0] output_width;
		logic [13:0] output_height;
		logic [20:0] buffer_bytes_used;
	} cfg_t;

	typedef struct packed {
		logic        cmd;
		logic [19:0] byte_address;
		logic [7:0]  byte_value;
		logic [12:0] out_x;
		logic [12:0] out_y;
		logic        range_bad;
	} item_t;

endpackage

@@ hw/rtl/rbud_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
module rbud_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wa,
	input  logic [WIDTH-1:0] wd,
	input  logic             re,
	input  logic [AW-1:0]    ra0,
	input  logic [AW-1:0]    ra1,
	output logic [WIDTH-1:0] rd0,
	output logic [WIDTH-1:0] rd1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd0 <= mem[ra0];
			rd1 <= mem[ra1];
		end
	end

endmodule

@@ hw/rtl/rbud_cfg_chk.sv @@
// Two-stage registered check of the configuration registers.
module rbud_cfg_chk import rbud_pkg::*; #(
	parameter int BUFFER_BYTES = 1048576,
	parameter int MAX_DIM      = 8192
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	output logic cfg_ok
);

	function automatic logic dim_ok(input logic [QW-1:0] d);
		return (d != '0) && !d[0] && (32'(d) <= MAX_DIM);
	endfunction

	logic        base_ok_q;
	logic [17:0] min_row_q;
	logic [29:0] hm1_rs_q;

	logic [3:0]  stride;
	logic [14:0] sw_r10, sw_r12;
	logic [17:0] min_row;
	logic        fmt_ok, base_ok;
	logic [30:0] min_bytes;

	always_comb begin
		stride = (cfg.pixel_stride < 4'd2) ? 4'd2 : cfg.pixel_stride;
		sw_r10 = (15'(cfg.source_width) + 15'd3) >> 2;
		sw_r12 = (15'(cfg.source_width) + 15'd1) >> 1;
		fmt_ok = 1'b1;
		case (cfg.pixel_format)
			FMT_RAW10: begin
				min_row = 18'(sw_r10) + (18'(sw_r10) << 2);
				fmt_ok  = (cfg.source_width[1:0] == 2'd0);
			end
			FMT_RAW12: begin
				min_row = 18'(sw_r12) + (18'(sw_r12) << 1);
				fmt_ok  = (cfg.source_width[1:0] == 2'd0);
			end
			FMT_RAW16: min_row = 18'(cfg.source_width) * 18'(stride);
			default: begin
				min_row = '0;
				fmt_ok  = 1'b0;
			end
		endcase
		// (source height - 1) times row stride plus the minimum row cannot reach 2^31 at these field widths
		base_ok = dim_ok(cfg.source_width) && dim_ok(cfg.source_height) &&
			dim_ok(cfg.output_width) && dim_ok(cfg.output_height) &&
			(cfg.output_width <= cfg.source_width) &&
			(cfg.output_height <= cfg.source_height) &&
			(cfg.row_stride != '0) && (cfg.buffer_bytes_used != '0) &&
			(32'(cfg.buffer_bytes_used) <= BUFFER_BYTES) && fmt_ok;
		min_bytes = 31'(hm1_rs_q) + 31'(min_row_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_ok_q <= 1'b0;
			min_row_q <= '0;
			hm1_rs_q  <= '0;
			cfg_ok    <= 1'b0;
		end else begin
			base_ok_q <= base_ok;
			min_row_q <= min_row;
			hm1_rs_q  <= 30'(cfg.source_height - 14'd1) * 30'(cfg.row_stride);
			cfg_ok    <= base_ok_q && (18'(cfg.row_stride) >= min_row_q) &&
				(31'(cfg.buffer_bytes_used) >= min_bytes);
		end
	end

endmodule

@@ hw/rtl/rbud_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, x and y lanes.
module rbud_div import rbud_pkg::*; (
	input  logic          clk,
	input  logic [QW-1:0] ld,
	input  item_t         it_i,
	input  logic [NW-1:0] nx_i,
	input  logic [NW-1:0] ny_i,
	input  logic [DW-1:0] dx,
	input  logic [DW-1:0] dy,
	output item_t         it_o,
	output logic [QW-1:0] qx_o,
	output logic [QW-1:0] qy_o
);

	localparam int XW = NW + 1;

	item_t         it_s [QW];
	logic [NW-1:0] rx_s [QW];
	logic [NW-1:0] ry_s [QW];
	logic [QW-1:0] qx_s [QW];
	logic [QW-1:0] qy_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_st
		localparam int B = QW - 1 - i;
		item_t         it_in;
		logic [NW-1:0] rx_in, ry_in;
		logic [QW-1:0] qx_in, qy_in;
		logic [XW-1:0] dxs, dys;

		if (i == 0) begin : g_first
			assign it_in = it_i;
			assign rx_in = nx_i;
			assign ry_in = ny_i;
			assign qx_in = '0;
			assign qy_in = '0;
		end else begin : g_next
			assign it_in = it_s[i-1];
			assign rx_in = rx_s[i-1];
			assign ry_in = ry_s[i-1];
			assign qx_in = qx_s[i-1];
			assign qy_in = qy_s[i-1];
		end

		assign dxs = XW'(dx) << B;
		assign dys = XW'(dy) << B;

		always_ff @(posedge clk) begin
			if (ld[i]) begin
				it_s[i] <= it_in;
				if (XW'(rx_in) >= dxs) begin
					rx_s[i] <= NW'(XW'(rx_in) - dxs);
					qx_s[i] <= qx_in | (QW'(1) << B);
				end else begin
					rx_s[i] <= rx_in;
					qx_s[i] <= qx_in;
				end
				if (XW'(ry_in) >= dys) begin
					ry_s[i] <= NW'(XW'(ry_in) - dys);
					qy_s[i] <= qy_in | (QW'(1) << B);
				end else begin
					ry_s[i] <= ry_in;
					qy_s[i] <= qy_in;
				end
			end
		end
	end

	assign it_o = it_s[QW-1];
	assign qx_o = qx_s[QW-1];
	assign qy_o = qy_s[QW-1];

endmodule

@@ hw/rtl/raw_bayer_unpack_downscale.sv @@
// Top level: packed RAW frame store with centre-aligned nearest downscaling and unpack.
// Throughput: one word per cycle, write or decode; each stage holds only while the one after
// it is full and stalled, so bubbles close up. The 14-stage divider sets the depth.
// Reset: configuration registers return to their defaults, all stage valid bits clear.
// The frame store itself is not cleared; a byte reads back only after it was written.
module raw_bayer_unpack_downscale import rbud_pkg::*; #(
	parameter int BUFFER_BYTES = 1048576,
	parameter int MAX_DIM      = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// byte_address[19:0], byte_value[27:20], out_x[40:28], out_y[53:41], zero pad
	input  logic [55:0] s_tdata,
	// command
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// sample[15:0], source_x[28:16], source_y[41:29], zero pad
	output logic [47:0] m_tdata,
	// status
	output logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [20:0] cfg_data
);

	localparam int AW    = $clog2(BUFFER_BYTES);
	localparam int S_ADJ = QW + 3;		// parity / clamp
	localparam int S_ROW = QW + 4;		// row product, column offsets
	localparam int S_ADR = QW + 5;		// byte addresses, fit check
	localparam int S_RD  = QW + 6;		// store read / write
	localparam int NS    = QW + 7;		// output word

	// configuration registers
	cfg_t cfg_q;
	logic cfg_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format      <= FMT_RAW10;
			cfg_q.source_width      <= 14'd4000;
			cfg_q.source_height     <= 14'd3000;
			cfg_q.row_stride        <= 16'd5000;
			cfg_q.pixel_stride      <= 4'd2;
			cfg_q.output_width      <= 14'd4000;
			cfg_q.output_height     <= 14'd3000;
			cfg_q.buffer_bytes_used <= 21'd1048576;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PIXEL_FORMAT:  cfg_q.pixel_format      <= cfg_data[1:0];
				REG_SOURCE_WIDTH:  cfg_q.source_width      <= cfg_data[13:0];
				REG_SOURCE_HEIGHT: cfg_q.source_height     <= cfg_data[13:0];
				REG_ROW_STRIDE:    cfg_q.row_stride        <= cfg_data[15:0];
				REG_PIXEL_STRIDE:  cfg_q.pixel_stride      <= cfg_data[3:0];
				REG_OUTPUT_WIDTH:  cfg_q.output_width      <= cfg_data[13:0];
				REG_OUTPUT_HEIGHT: cfg_q.output_height     <= cfg_data[13:0];
				REG_BUF_USED:      cfg_q.buffer_bytes_used <= cfg_data;
				default: ;
			endcase
		end
	end

	// user must hold config static while words fly (unenforced), so the check settles before use
	rbud_cfg_chk #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.MAX_DIM     (MAX_DIM)
	) u_cfg_chk (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.cfg_ok(cfg_ok)
	);

	// stage handshake: a stage loads when empty or when the next one loads
	logic [NS:1]   vld_s;
	logic [NS+1:1] ld;

	always_comb begin
		ld[NS+1] = m_tready;
		for (int k = NS; k >= 1; k--) begin
			ld[k] = !vld_s[k] || ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ld[1]) begin
				vld_s[1] <= s_tvalid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (ld[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign s_tready = ld[1];
	assign m_tvalid = vld_s[NS];

	// s1: capture word, range check
	item_t it_s1;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			it_s1.cmd          <= s_tuser;
			it_s1.byte_address <= s_tdata[19:0];
			it_s1.byte_value   <= s_tdata[27:20];
			it_s1.out_x        <= s_tdata[40:28];
			it_s1.out_y        <= s_tdata[53:41];
			it_s1.range_bad    <= (14'(s_tdata[40:28]) >= cfg_q.output_width) ||
				(14'(s_tdata[53:41]) >= cfg_q.output_height);
		end
	end

	// s2: numerators (2c+1)*S
	item_t         it_s2;
	logic [NW-1:0] nx_s2, ny_s2;

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			it_s2 <= it_s1;
			nx_s2 <= NW'({it_s1.out_x, 1'b1}) * NW'(cfg_q.source_width);
			ny_s2 <= NW'({it_s1.out_y, 1'b1}) * NW'(cfg_q.source_height);
		end
	end

	// s3..s16: quotient by 2*O
	item_t         it_dv;
	logic [QW-1:0] qx_dv, qy_dv;

	rbud_div u_div (
		.clk (clk),
		.ld  (ld[S_ADJ-1:3]),
		.it_i(it_s2),
		.nx_i(nx_s2),
		.ny_i(ny_s2),
		.dx  ({cfg_q.output_width, 1'b0}),
		.dy  ({cfg_q.output_height, 1'b0}),
		.it_o(it_dv),
		.qx_o(qx_dv),
		.qy_o(qy_dv)
	);

	// pass c through when O equals S; else clamp to S-1, then nudge parity to keep the Bayer phase
	function automatic logic [QW-1:0] map_adj(input logic [12:0] c,
		input logic [QW-1:0] q, input logic [QW-1:0] o, input logic [QW-1:0] s);
		logic [QW-1:0] v;
		if (o == s) begin
			v = QW'(c);
		end else begin
			v = (q > s - 14'd1) ? s - 14'd1 : q;
			if (v[0] != c[0]) begin
				if (15'(v) + 15'd1 < 15'(s)) begin
					v = v + 14'd1;
				end else if (v != '0) begin
					v = v - 14'd1;
				end
			end
		end
		return v;
	endfunction

	item_t         it_s17;
	logic [QW-1:0] sx_s17, sy_s17;

	always_ff @(posedge clk) begin
		if (ld[S_ADJ]) begin
			it_s17 <= it_dv;
			sx_s17 <= map_adj(it_dv.out_x, qx_dv, cfg_q.output_width, cfg_q.source_width);
			sy_s17 <= map_adj(it_dv.out_y, qy_dv, cfg_q.output_height, cfg_q.source_height);
		end
	end

	// s18: row start and offsets within the row
	item_t         it_s18;
	logic [QW-1:0] sx_s18, sy_s18;
	logic [PW-1:0] prow_s18;
	logic [17:0]   col_lane_s18, col_last_s18;
	logic [1:0]    lane_s18;

	logic [3:0]  stride;
	logic [11:0] grp4;
	logic [12:0] grp2;
	logic [17:0] col;
	logic [1:0]  lane;
	logic [2:0]  last;

	always_comb begin
		stride = (cfg_q.pixel_stride < 4'd2) ? 4'd2 : cfg_q.pixel_stride;
		grp4   = sx_s17[13:2];
		grp2   = sx_s17[13:1];
		case (cfg_q.pixel_format)
			FMT_RAW10: begin
				col  = 18'(grp4) + (18'(grp4) << 2);
				lane = sx_s17[1:0];
				last = 3'd4;
			end
			FMT_RAW12: begin
				col  = 18'(grp2) + (18'(grp2) << 1);
				lane = {1'b0, sx_s17[0]};
				last = 3'd2;
			end
			default: begin
				col  = 18'(sx_s17) * 18'(stride);
				lane = 2'd0;
				last = 3'd1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld[S_ROW]) begin
			it_s18       <= it_s17;
			sx_s18       <= sx_s17;
			sy_s18       <= sy_s17;
			prow_s18     <= PW'(sy_s17) * PW'(cfg_q.row_stride);
			col_lane_s18 <= col + 18'(lane);
			col_last_s18 <= col + 18'(last);
			lane_s18     <= lane;
		end
	end

	// s19: byte addresses; the last byte needed must lie below the used size
	item_t         it_s19;
	logic [QW-1:0] sx_s19, sy_s19;
	logic [PW-1:0] a0_s19, a1_s19;
	logic [1:0]    lane_s19;
	logic          fits_s19;
	logic [PW-1:0] a1_nx;

	assign a1_nx = prow_s18 + PW'(col_last_s18);

	always_ff @(posedge clk) begin
		if (ld[S_ADR]) begin
			it_s19   <= it_s18;
			sx_s19   <= sx_s18;
			sy_s19   <= sy_s18;
			a0_s19   <= prow_s18 + PW'(col_lane_s18);
			a1_s19   <= a1_nx;
			fits_s19 <= a1_nx < PW'(cfg_q.buffer_bytes_used);
			lane_s19 <= lane_s18;
		end
	end

	// s20: store access; writes and reads share one point so order is kept
	item_t         it_s20;
	logic [QW-1:0] sx_s20, sy_s20;
	logic [1:0]    lane_s20;
	logic          fits_s20;
	logic [7:0]    d0, d1;
	logic          st_we;

	assign st_we = ld[S_RD] && vld_s[S_RD-1] && (it_s19.cmd == CMD_WRITE) &&
		(32'(it_s19.byte_address) < BUFFER_BYTES);

	rbud_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_store (
		.clk(clk),
		.we (st_we),
		.wa (AW'(it_s19.byte_address)),
		.wd (it_s19.byte_value),
		.re (ld[S_RD]),
		.ra0(a0_s19[AW-1:0]),
		.ra1(a1_s19[AW-1:0]),
		.rd0(d0),
		.rd1(d1)
	);

	always_ff @(posedge clk) begin
		if (ld[S_RD]) begin
			it_s20   <= it_s19;
			sx_s20   <= sx_s19;
			sy_s20   <= sy_s19;
			lane_s20 <= lane_s19;
			fits_s20 <= fits_s19;
		end
	end

	// s21: unpack and status, output register
	logic [15:0] sample_s21;
	logic [1:0]  status_s21;
	logic [12:0] srcx_s21, srcy_s21;

	logic [15:0] smp;
	logic [7:0]  lo_bits;

	always_comb begin
		lo_bits = d1 >> {lane_s20, 1'b0};
		case (cfg_q.pixel_format)
			FMT_RAW10: smp = {6'd0, d0, lo_bits[1:0]};
			FMT_RAW12: smp = {4'd0, d0, lane_s20[0] ? d1[7:4] : d1[3:0]};
			default:   smp = {d1, d0};
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld[NS]) begin
			sample_s21 <= '0;
			srcx_s21   <= '0;
			srcy_s21   <= '0;
			status_s21 <= ST_OK;
			if (it_s20.cmd == CMD_DECODE) begin
				if (!cfg_ok) begin
					status_s21 <= ST_BAD_CFG;
				end else if (it_s20.range_bad) begin
					status_s21 <= ST_RANGE;
				end else begin
					srcx_s21 <= sx_s20[12:0];
					srcy_s21 <= sy_s20[12:0];
					if (fits_s20) begin
						sample_s21 <= smp;
					end else begin
						status_s21 <= ST_OFFSET;
					end
				end
			end
		end
	end

	assign m_tdata = {6'd0, srcy_s21, srcx_s21, sample_s21};
	assign m_tuser = status_s21;

endmodule
